>>> rtl/dpq_pkg.sv
package dpq_pkg;

   // Number of values the queue can hold, and the widths that follow from it.
   localparam int CAPACITY = 256;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int VALUE_WIDTH = 32;
   localparam int ENTRY_COUNT_WIDTH = 9;
   localparam int OPERATION_WIDTH = 2;

   // Operation codes carried on req_operation; the fourth code does nothing.
   typedef enum logic [OPERATION_WIDTH-1:0] {
      OP_INSERT     = 2'd0,
      OP_DELETE_MAX = 2'd1,
      OP_DELETE_MIN = 2'd2
   } op_type;

   // Decoded command broadcast to every cell of the chain.
   typedef struct packed {
      logic                          insert;
      logic                          delete_max;
      logic                          delete_min;
      logic signed [VALUE_WIDTH-1:0] value;
   } cmd_type;

   // What one cell shows to its neighbours. The ascending chain keeps the
   // smallest value in cell 0, the descending chain keeps the largest there.
   typedef struct packed {
      logic                          valid;
      logic                          asc_move;
      logic                          desc_move;
      logic signed [VALUE_WIDTH-1:0] asc_value;
      logic signed [VALUE_WIDTH-1:0] desc_value;
   } link_type;

endpackage

>>> rtl/dpq_cell.sv
module dpq_cell (
   input  logic              clock,
   input  logic              reset,
   input  dpq_pkg::cmd_type  cmd,
   input  dpq_pkg::link_type link_lo,
   input  dpq_pkg::link_type link_hi,
   output dpq_pkg::link_type link_out
);

   logic                                   valid_ff;
   logic                                   valid_in;
   logic signed [dpq_pkg::VALUE_WIDTH-1:0] asc_ff;
   logic signed [dpq_pkg::VALUE_WIDTH-1:0] asc_in;
   logic signed [dpq_pkg::VALUE_WIDTH-1:0] desc_ff;
   logic signed [dpq_pkg::VALUE_WIDTH-1:0] desc_in;
   logic                                   asc_move;
   logic                                   desc_move;

   // An empty cell counts as beyond every value, so an insert always lands
   // at the first empty cell when no held value has to move.
   always_comb begin
      asc_move  = !valid_ff || ($signed(asc_ff) > $signed(cmd.value));
      desc_move = !valid_ff || ($signed(desc_ff) < $signed(cmd.value));
   end

   // Next contents: on insert, cells that move take their lower neighbour's
   // value and the lowest moving cell takes the new value; on delete, one
   // chain shifts down by one while the other simply loses its top entry.
   always_comb begin
      valid_in = valid_ff;
      asc_in   = asc_ff;
      desc_in  = desc_ff;
      if (cmd.insert) begin
         valid_in = link_lo.valid;
         if (asc_move) begin
            asc_in = link_lo.asc_move ? link_lo.asc_value : cmd.value;
         end
         if (desc_move) begin
            desc_in = link_lo.desc_move ? link_lo.desc_value : cmd.value;
         end
      end else if (cmd.delete_min) begin
         valid_in = link_hi.valid;
         asc_in   = link_hi.asc_value;
      end else if (cmd.delete_max) begin
         valid_in = link_hi.valid;
         desc_in  = link_hi.desc_value;
      end
   end

   // The occupancy bit is control state; the values need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      asc_ff  <= asc_in;
      desc_ff <= desc_in;
   end

   always_comb begin
      link_out.valid      = valid_ff;
      link_out.asc_move   = asc_move;
      link_out.desc_move  = desc_move;
      link_out.asc_value  = asc_ff;
      link_out.desc_value = desc_ff;
   end

endmodule

>>> rtl/double_ended_priority_queue.sv
// Double-ended priority queue of up to 256 signed 32-bit values. An operation
// is taken at every clock edge where start is high; busy stays low, so one
// operation per cycle is sustained. Each cell of a row of 256 updates itself
// from its neighbours, and the result of an operation appears on the rsp_
// ports in the following cycle, marked by rsp_strobe. There is no way to
// hold a result back: the receiver must take every transfer in the cycle it
// is shown. Deleting from an empty queue changes nothing, and an insert into
// a full queue is dropped and flagged by rsp_insert_dropped. When the queue
// is empty both extremes read as zero.
module double_ended_priority_queue (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic [dpq_pkg::OPERATION_WIDTH-1:0]          req_operation,
   input  logic signed [dpq_pkg::VALUE_WIDTH-1:0]       req_value,
   output logic                                         rsp_strobe,
   output logic signed [dpq_pkg::VALUE_WIDTH-1:0]       rsp_max_value,
   output logic signed [dpq_pkg::VALUE_WIDTH-1:0]       rsp_min_value,
   output logic [dpq_pkg::ENTRY_COUNT_WIDTH-1:0]        rsp_entry_count,
   output logic                                         rsp_is_empty,
   output logic                                         rsp_insert_dropped
);

   localparam logic [dpq_pkg::COUNT_WIDTH-1:0] FULL_COUNT =
      dpq_pkg::COUNT_WIDTH'(dpq_pkg::CAPACITY);

   dpq_pkg::cmd_type                    cmd;
   dpq_pkg::link_type                   links [dpq_pkg::CAPACITY];
   dpq_pkg::link_type                   bottom_link;
   dpq_pkg::link_type                   top_link;
   logic [dpq_pkg::COUNT_WIDTH-1:0]     count_ff;
   logic [dpq_pkg::COUNT_WIDTH-1:0]     count_in;
   logic                                strobe_ff;
   logic                                dropped_ff;
   logic                                dropped_in;
   logic                                full;
   logic                                empty;
   logic                                accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == FULL_COUNT);
   assign empty  = (count_ff == '0);

   // Decode the operation into the command seen by every cell.
   always_comb begin
      cmd.insert     = 1'b0;
      cmd.delete_max = 1'b0;
      cmd.delete_min = 1'b0;
      cmd.value      = req_value;
      dropped_in     = 1'b0;
      count_in       = count_ff;
      if (accept) begin
         case (req_operation)
            dpq_pkg::OP_INSERT: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            dpq_pkg::OP_DELETE_MAX: begin
               if (!empty) begin
                  cmd.delete_max = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
            dpq_pkg::OP_DELETE_MIN: begin
               if (!empty) begin
                  cmd.delete_min = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Boundary links: below cell 0 is an always-occupied, never-moving slot;
   // above the last cell nothing is held.
   always_comb begin
      bottom_link.valid      = 1'b1;
      bottom_link.asc_move   = 1'b0;
      bottom_link.desc_move  = 1'b0;
      bottom_link.asc_value  = '0;
      bottom_link.desc_value = '0;
      top_link.valid         = 1'b0;
      top_link.asc_move      = 1'b1;
      top_link.desc_move     = 1'b1;
      top_link.asc_value     = '0;
      top_link.desc_value    = '0;
   end

   // The row of cells.
   for (genvar i = 0; i < dpq_pkg::CAPACITY; i++) begin : g_cell
      dpq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .link_lo  ((i == 0) ? bottom_link : links[(i == 0) ? 0 : i - 1]),
         .link_hi  ((i == dpq_pkg::CAPACITY - 1) ? top_link :
                    links[(i == dpq_pkg::CAPACITY - 1) ? i : i + 1]),
         .link_out (links[i])
      );
   end

   // Count, strobe and drop flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         strobe_ff  <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         strobe_ff  <= accept;
         dropped_ff <= dropped_in;
      end
   end

   // The extremes sit in cell 0 of each chain once the operation has landed.
   always_comb begin
      rsp_strobe         = strobe_ff;
      rsp_max_value      = empty ? '0 : links[0].desc_value;
      rsp_min_value      = empty ? '0 : links[0].asc_value;
      rsp_entry_count    = dpq_pkg::ENTRY_COUNT_WIDTH'(count_ff);
      rsp_is_empty       = empty;
      rsp_insert_dropped = dropped_ff;
   end

   // The count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("entry count beyond capacity");

   // Every accepted operation yields exactly one result in the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> rsp_strobe)
      else $error("result missing after accepted operation");

   assert property (@(posedge clock) disable iff (reset) !accept |=> !rsp_strobe)
      else $error("result without accepted operation");

   // Occupancy of the bottom cell agrees with the count.
   assert property (@(posedge clock) disable iff (reset)
      links[0].valid == !empty)
      else $error("bottom cell occupancy disagrees with count");

   // A non-empty queue never reports a minimum above its maximum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_is_empty) |-> ($signed(rsp_min_value) <= $signed(rsp_max_value)))
      else $error("minimum above maximum");

endmodule
